>>> rtl/core/ddagr_pkg.sv
package ddagr_pkg;

   localparam int unsigned ONE_FIX  = 65536;
   localparam int unsigned OUT_CEIL = (127 * 65536) / 8;
   localparam logic [30:0] RECIP_MAX = 31'h7FFF_FFFF;
   localparam int unsigned CW = 18;

   localparam logic [1:0] FACE_YN = 2'd0;
   localparam logic [1:0] FACE_XN = 2'd1;
   localparam logic [1:0] FACE_YP = 2'd2;
   localparam logic [1:0] FACE_XP = 2'd3;

   localparam logic [1:0] REG_STEP_LIMIT  = 2'd0;
   localparam logic [1:0] REG_SKY_TEXTURE = 2'd1;
   localparam logic [1:0] REG_MAP_WIDTH   = 2'd2;
   localparam logic [1:0] REG_MAP_HEIGHT  = 2'd3;

   typedef struct packed {
      logic [6:0]  step_limit;
      logic [15:0] sky_texture;
      logic [6:0]  map_width;
      logic [6:0]  map_height;
   } cfg_type;

   typedef struct packed {
      logic               req_type;
      logic signed [31:0] ray_x;
      logic signed [31:0] ray_y;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic [11:0]        cell_index;
      logic [15:0]        new_wall_floor_tex;
      logic [15:0]        new_wall_ceil_tex;
      logic signed [31:0] new_floor_height;
      logic signed [31:0] new_ceil_height;
      logic [15:0]        new_floor_tex;
      logic [15:0]        new_ceil_tex;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] hit_cell_x;
      logic signed [15:0] hit_cell_y;
      logic signed [31:0] hit_along;
      logic signed [31:0] hit_distance;
      logic [1:0]         face;
      logic [15:0]        wall_floor_tex;
      logic [15:0]        wall_ceil_tex;
      logic signed [31:0] near_floor_height;
      logic signed [31:0] near_ceil_height;
      logic [15:0]        near_floor_tex;
      logic [15:0]        near_ceil_tex;
      logic               last_hit;
   } rsp_payload_type;

   typedef struct packed {
      logic [15:0]        wall_lo_tex;
      logic [15:0]        wall_hi_tex;
      logic signed [31:0] fheight;
      logic signed [31:0] cheight;
      logic [15:0]        ftex;
      logic [15:0]        ctex;
   } cell_type;

   typedef struct packed {
      logic capture;
      logic write_cell;
      logic div_start;
      logic div_sel_y;
      logic mul_x;
      logic mul_y;
      logic set_y;
      logic step;
      logic load;
      logic last;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic out_free;
   } status_type;

endpackage

>>> rtl/core/ddagr_if.sv
interface ddagr_req_if;
   logic               valid;
   logic               ready;
   logic               req_type;
   logic signed [31:0] ray_x;
   logic signed [31:0] ray_y;
   logic signed [31:0] dir_x;
   logic signed [31:0] dir_y;
   logic [11:0]        cell_index;
   logic [15:0]        new_wall_floor_tex;
   logic [15:0]        new_wall_ceil_tex;
   logic signed [31:0] new_floor_height;
   logic signed [31:0] new_ceil_height;
   logic [15:0]        new_floor_tex;
   logic [15:0]        new_ceil_tex;

   modport source (output valid, req_type, ray_x, ray_y, dir_x, dir_y, cell_index,
                   new_wall_floor_tex, new_wall_ceil_tex, new_floor_height,
                   new_ceil_height, new_floor_tex, new_ceil_tex, input ready);
   modport sink (input valid, req_type, ray_x, ray_y, dir_x, dir_y, cell_index,
                 new_wall_floor_tex, new_wall_ceil_tex, new_floor_height,
                 new_ceil_height, new_floor_tex, new_ceil_tex, output ready);
endinterface

interface ddagr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] hit_cell_x;
   logic signed [15:0] hit_cell_y;
   logic signed [31:0] hit_along;
   logic signed [31:0] hit_distance;
   logic [1:0]         face;
   logic [15:0]        wall_floor_tex;
   logic [15:0]        wall_ceil_tex;
   logic signed [31:0] near_floor_height;
   logic signed [31:0] near_ceil_height;
   logic [15:0]        near_floor_tex;
   logic [15:0]        near_ceil_tex;
   logic               last_hit;

   modport source (output valid, hit_cell_x, hit_cell_y, hit_along, hit_distance, face,
                   wall_floor_tex, wall_ceil_tex, near_floor_height, near_ceil_height,
                   near_floor_tex, near_ceil_tex, last_hit, input ready);
   modport sink (input valid, hit_cell_x, hit_cell_y, hit_along, hit_distance, face,
                 wall_floor_tex, wall_ceil_tex, near_floor_height, near_ceil_height,
                 near_floor_tex, near_ceil_tex, last_hit, output ready);
endinterface

>>> rtl/core/ddagr_ctrl.sv
module ddagr_ctrl #(
   parameter int MAX_HITS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_is_cast,
   output logic                   req_ready,
   input  logic [6:0]             step_limit,
   input  ddagr_pkg::status_type  st,
   output ddagr_pkg::cmd_type     cmd
);
   import ddagr_pkg::*;

   localparam int HW = $clog2(MAX_HITS + 1);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_DIVX = 7'b0000010,
      ST_DIVY = 7'b0000100,
      ST_MULX = 7'b0001000,
      ST_MULY = 7'b0010000,
      ST_SETY = 7'b0100000,
      ST_STEP = 7'b1000000
   } state_type;

   // The load of a result waits after the step state until the output is free, tracked here.
   state_type      state_ff, state_in;
   logic           load_ff, load_in;
   logic [HW-1:0]  hit_cnt_ff, hit_cnt_in;
   logic [HW-1:0]  limit_ff, limit_in;
   logic [HW-1:0]  limit_now;
   logic           accept;

   assign limit_now = (step_limit > 7'(MAX_HITS)) ? HW'(MAX_HITS) : HW'(step_limit);
   assign req_ready = (state_ff == ST_IDLE) && !load_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      load_in    = load_ff;
      hit_cnt_in = hit_cnt_ff;
      limit_in   = limit_ff;
      cmd.last   = (hit_cnt_ff == limit_ff - HW'(1));
      if (load_ff) begin
         if (st.out_free) begin
            cmd.load   = 1'b1;
            load_in    = 1'b0;
            hit_cnt_in = hit_cnt_ff + HW'(1);
            state_in   = cmd.last ? ST_IDLE : ST_STEP;
         end
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_is_cast) begin
                     cmd.capture = 1'b1;
                     limit_in    = limit_now;
                     hit_cnt_in  = '0;
                     if (limit_now != '0) begin
                        cmd.div_start = 1'b1;
                        state_in      = ST_DIVX;
                     end
                  end else begin
                     cmd.write_cell = 1'b1;
                  end
               end
            end
            ST_DIVX: begin
               if (st.div_done) begin
                  cmd.div_start = 1'b1;
                  cmd.div_sel_y = 1'b1;
                  state_in      = ST_DIVY;
               end
            end
            ST_DIVY: begin
               if (st.div_done) begin
                  state_in = ST_MULX;
               end
            end
            ST_MULX: begin
               cmd.mul_x = 1'b1;
               state_in  = ST_MULY;
            end
            ST_MULY: begin
               cmd.mul_y = 1'b1;
               state_in  = ST_SETY;
            end
            ST_SETY: begin
               cmd.set_y = 1'b1;
               state_in  = ST_STEP;
            end
            ST_STEP: begin
               cmd.step = 1'b1;
               load_in  = 1'b1;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         load_ff    <= 1'b0;
         hit_cnt_ff <= '0;
         limit_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         load_ff    <= load_in;
         hit_cnt_ff <= hit_cnt_in;
         limit_ff   <= limit_in;
      end
   end

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && cmd.last) |=> (state_ff == ST_IDLE && !load_ff))
      else $error("final hit did not return the controller to idle");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> (hit_cnt_ff < limit_ff))
      else $error("hit counter ran past the step limit");

   a_div_follows: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> (state_ff == ST_DIVX || state_ff == ST_DIVY))
      else $error("divider started outside a divide state");

endmodule

>>> rtl/core/ddagr_datapath.sv
module ddagr_datapath #(
   parameter int MAP_SIDE = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ddagr_pkg::cfg_type          cfg,
   input  ddagr_pkg::req_payload_type  req,
   input  ddagr_pkg::cmd_type          cmd,
   output ddagr_pkg::status_type       st,
   output ddagr_pkg::rsp_payload_type  rsp,
   output logic                        rsp_valid,
   input  logic                        rsp_ready
);
   import ddagr_pkg::*;

   localparam int CELLS = MAP_SIDE * MAP_SIDE;
   localparam int AW    = $clog2(CELLS);
   localparam int XB    = $clog2(MAP_SIDE);

   cell_type mem [CELLS];

   logic signed [31:0]   rx_ff, ry_ff, dx_ff, dy_ff;
   logic signed [CW-1:0] cx_ff, cy_ff;
   logic [30:0]          delx_ff, dely_ff;
   logic signed [31:0]   sdx_ff, sdy_ff;
   logic signed [31:0]   fprod_ff, dist_ff;
   logic [1:0]           face_ff;
   logic                 hit_in_ff, near_in_ff;
   cell_type             hit_cell_ff, near_cell_ff;
   rsp_payload_type      rsp_ff;
   logic                 rsp_valid_ff;

   logic [31:0]          m_ff;
   logic [31:0]          r_ff;
   logic [32:0]          q_ff;
   logic [5:0]           dcnt_ff;
   logic                 dactive_ff, dsel_ff;

   logic [8:0]           lim_w, lim_h;
   logic                 xneg, yneg, take_x;
   logic [16:0]          offx, offy;
   logic signed [CW-1:0] hx, hy;
   logic signed [31:0]   step_dist, mul_a, mul_b;
   logic signed [63:0]   mul_p;
   logic [AW-1:0]        wr_addr, hit_addr, near_addr;
   logic                 idx_ok;
   logic [31:0]          dsrc, dabs;
   logic [32:0]          rs, rn;
   logic                 ge;
   logic [32:0]          qf;
   logic [30:0]          qsat;
   logic signed [31:0]   along;
   logic [16:0]          idx_ext;

   function automatic logic in_map(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                   logic [8:0] w, logic [8:0] h);
      return !x[CW-1] && !y[CW-1] && ($unsigned(x) < CW'(w)) && ($unsigned(y) < CW'(h));
   endfunction

   function automatic logic [AW-1:0] addr_of(logic signed [CW-1:0] x,
                                             logic signed [CW-1:0] y);
      return AW'(AW'(y[XB-1:0]) * AW'(MAP_SIDE) + AW'(x[XB-1:0]));
   endfunction

   assign lim_w = (9'(cfg.map_width) < 9'(MAP_SIDE)) ? 9'(cfg.map_width) : 9'(MAP_SIDE);
   assign lim_h = (9'(cfg.map_height) < 9'(MAP_SIDE)) ? 9'(cfg.map_height) : 9'(MAP_SIDE);

   assign xneg = dx_ff[31];
   assign yneg = dy_ff[31];
   assign offx = xneg ? {1'b0, rx_ff[15:0]} : 17'(ONE_FIX) - {1'b0, rx_ff[15:0]};
   assign offy = yneg ? {1'b0, ry_ff[15:0]} : 17'(ONE_FIX) - {1'b0, ry_ff[15:0]};

   // Equal side distances step along y.
   assign take_x    = sdx_ff < sdy_ff;
   assign hx        = take_x ? (xneg ? cx_ff - CW'(1) : cx_ff + CW'(1)) : cx_ff;
   assign hy        = take_x ? cy_ff : (yneg ? cy_ff - CW'(1) : cy_ff + CW'(1));
   assign step_dist = take_x ? sdx_ff : sdy_ff;

   always_comb begin
      if (cmd.mul_x) begin
         mul_a = 32'(offx);
         mul_b = {1'b0, delx_ff};
      end else if (cmd.mul_y) begin
         mul_a = 32'(offy);
         mul_b = {1'b0, dely_ff};
      end else begin
         mul_a = step_dist;
         mul_b = take_x ? dy_ff : dx_ff;
      end
   end
   assign mul_p = mul_a * mul_b;

   // The near-side cell is the one the ray leaves, which is the current cell.
   assign hit_addr  = addr_of(hx, hy);
   assign near_addr = addr_of(cx_ff, cy_ff);
   assign idx_ext   = 17'(req.cell_index);
   assign idx_ok    = idx_ext < 17'(CELLS);
   assign wr_addr   = idx_ext[AW-1:0];

   // The x reciprocal starts in the capture cycle, before dx_ff holds the direction.
   assign dsrc = cmd.div_sel_y ? dy_ff : (cmd.capture ? req.dir_x : dx_ff);

   assign dabs = dsrc[31] ? 32'(-dsrc) : dsrc;
   assign rs   = {r_ff, (dcnt_ff == 6'd32)};
   assign ge   = rs >= {1'b0, m_ff};
   assign rn   = ge ? rs - {1'b0, m_ff} : rs;
   assign qf   = {q_ff[31:0], ge};
   assign qsat = (qf > {2'b00, RECIP_MAX}) ? RECIP_MAX : qf[30:0];

   assign st.div_done = dactive_ff && (dcnt_ff == 6'd0);
   assign st.out_free = !rsp_valid_ff || rsp_ready;

   assign along = ((face_ff == FACE_XN) || (face_ff == FACE_XP)) ? ry_ff + fprod_ff
                                                                 : rx_ff + fprod_ff;

   always_ff @(posedge clock) begin
      if (cmd.write_cell && idx_ok) begin
         mem[wr_addr] <= '{wall_lo_tex: req.new_wall_floor_tex,
                           wall_hi_tex: req.new_wall_ceil_tex,
                           fheight:     req.new_floor_height,
                           cheight:     req.new_ceil_height,
                           ftex:        req.new_floor_tex,
                           ctex:        req.new_ceil_tex};
      end
      if (cmd.step) begin
         hit_cell_ff  <= mem[hit_addr];
         near_cell_ff <= mem[near_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rx_ff <= req.ray_x;
         ry_ff <= req.ray_y;
         dx_ff <= req.dir_x;
         dy_ff <= req.dir_y;
         cx_ff <= CW'(signed'(req.ray_x[31:16]));
         cy_ff <= CW'(signed'(req.ray_y[31:16]));
      end
      if (dactive_ff) begin
         r_ff <= rn[31:0];
         q_ff <= qf;
         if (dcnt_ff == 6'd0) begin
            if (dsel_ff) begin
               dely_ff <= qsat;
            end else begin
               delx_ff <= qsat;
            end
         end else begin
            dcnt_ff <= dcnt_ff - 6'd1;
         end
      end
      if (cmd.div_start) begin
         m_ff    <= (dabs == 32'd0) ? 32'd1 : dabs;
         r_ff    <= '0;
         q_ff    <= '0;
         dcnt_ff <= 6'd32;
         dsel_ff <= cmd.div_sel_y;
      end
      if (cmd.mul_x || cmd.mul_y || cmd.step) begin
         fprod_ff <= mul_p[47:16];
      end
      if (cmd.mul_y) begin
         sdx_ff <= fprod_ff;
      end
      if (cmd.set_y) begin
         sdy_ff <= fprod_ff;
      end
      if (cmd.step) begin
         if (take_x) begin
            sdx_ff  <= sdx_ff + $signed({1'b0, delx_ff});
            face_ff <= xneg ? FACE_XN : FACE_XP;
         end else begin
            sdy_ff  <= sdy_ff + $signed({1'b0, dely_ff});
            face_ff <= yneg ? FACE_YN : FACE_YP;
         end
         cx_ff      <= hx;
         cy_ff      <= hy;
         dist_ff    <= step_dist;
         hit_in_ff  <= in_map(hx, hy, lim_w, lim_h);
         near_in_ff <= in_map(cx_ff, cy_ff, lim_w, lim_h);
      end
      if (cmd.load) begin
         rsp_ff.hit_cell_x   <= cx_ff[15:0];
         rsp_ff.hit_cell_y   <= cy_ff[15:0];
         rsp_ff.hit_along    <= along;
         rsp_ff.hit_distance <= dist_ff;
         rsp_ff.face         <= face_ff;
         rsp_ff.last_hit     <= cmd.last;
         if (hit_in_ff) begin
            rsp_ff.wall_floor_tex <= hit_cell_ff.wall_lo_tex;
            rsp_ff.wall_ceil_tex  <= hit_cell_ff.wall_hi_tex;
         end else begin
            rsp_ff.wall_floor_tex <= cfg.sky_texture;
            rsp_ff.wall_ceil_tex  <= cfg.sky_texture;
         end
         if (near_in_ff) begin
            rsp_ff.near_floor_height <= near_cell_ff.fheight;
            rsp_ff.near_ceil_height  <= near_cell_ff.cheight;
            rsp_ff.near_floor_tex    <= near_cell_ff.ftex;
            rsp_ff.near_ceil_tex     <= near_cell_ff.ctex;
         end else begin
            rsp_ff.near_floor_height <= '0;
            rsp_ff.near_ceil_height  <= 32'(OUT_CEIL);
            rsp_ff.near_floor_tex    <= cfg.sky_texture;
            rsp_ff.near_ceil_tex     <= cfg.sky_texture;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dactive_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.div_start) begin
            dactive_ff <= 1'b1;
         end else if (st.div_done) begin
            dactive_ff <= 1'b0;
         end
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp       = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/core/dda_grid_ray_multi_hit_core.sv
// Channel     Direction  Transaction
// req_chan    in         map cell write, or ray cast (16.16 origin and direction)
// rsp_chan    out        one hit per DDA step, last_hit on the final one
// csr_*       in/out     step_limit, sky_texture, map_width, map_height
//
// A cell write completes in the cycle it is accepted and returns nothing.
// A cast computes the two reciprocals in turn in the shared radix-2 divider,
// seeds the side distances (MULX, MULY, SETY), then for each hit reads the map
// and loads the result register.
// Reset is synchronous; the map memory is not cleared and must be written first.
// A stalled result holds the datapath in place until it is taken.
module dda_grid_ray_multi_hit_core #(
   parameter int MAP_SIDE = 64,
   parameter int MAX_HITS = 64
) (
   input  logic         clock,
   input  logic         reset,
   ddagr_req_if.sink    req_chan,
   ddagr_rsp_if.source  rsp_chan,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import ddagr_pkg::*;

   logic [6:0]      step_limit_ff;
   logic [15:0]     sky_texture_ff;
   logic [6:0]      map_width_ff;
   logic [6:0]      map_height_ff;
   logic            csr_wr;
   cfg_type         cfg;
   req_payload_type req;
   rsp_payload_type rsp;
   cmd_type         cmd;
   status_type      st;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_limit_ff  <= 7'd64;
         sky_texture_ff <= 16'd0;
         map_width_ff   <= 7'd64;
         map_height_ff  <= 7'd64;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_STEP_LIMIT:  step_limit_ff  <= csr_pwdata[6:0];
            REG_SKY_TEXTURE: sky_texture_ff <= csr_pwdata[15:0];
            REG_MAP_WIDTH:   map_width_ff   <= csr_pwdata[6:0];
            REG_MAP_HEIGHT:  map_height_ff  <= csr_pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_STEP_LIMIT:  csr_prdata = 32'(step_limit_ff);
         REG_SKY_TEXTURE: csr_prdata = 32'(sky_texture_ff);
         REG_MAP_WIDTH:   csr_prdata = 32'(map_width_ff);
         REG_MAP_HEIGHT:  csr_prdata = 32'(map_height_ff);
         default:         csr_prdata = '0;
      endcase
   end

   assign cfg.step_limit  = step_limit_ff;
   assign cfg.sky_texture = sky_texture_ff;
   assign cfg.map_width   = map_width_ff;
   assign cfg.map_height  = map_height_ff;

   assign req.req_type           = req_chan.req_type;
   assign req.ray_x              = req_chan.ray_x;
   assign req.ray_y              = req_chan.ray_y;
   assign req.dir_x              = req_chan.dir_x;
   assign req.dir_y              = req_chan.dir_y;
   assign req.cell_index         = req_chan.cell_index;
   assign req.new_wall_floor_tex = req_chan.new_wall_floor_tex;
   assign req.new_wall_ceil_tex  = req_chan.new_wall_ceil_tex;
   assign req.new_floor_height   = req_chan.new_floor_height;
   assign req.new_ceil_height    = req_chan.new_ceil_height;
   assign req.new_floor_tex      = req_chan.new_floor_tex;
   assign req.new_ceil_tex       = req_chan.new_ceil_tex;

   ddagr_ctrl #(.MAX_HITS(MAX_HITS)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_is_cast (req_chan.req_type),
      .req_ready   (req_chan.ready),
      .step_limit  (step_limit_ff),
      .st          (st),
      .cmd         (cmd)
   );

   ddagr_datapath #(.MAP_SIDE(MAP_SIDE)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req       (req),
      .cmd       (cmd),
      .st        (st),
      .rsp       (rsp),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready)
   );

   assign rsp_chan.hit_cell_x        = rsp.hit_cell_x;
   assign rsp_chan.hit_cell_y        = rsp.hit_cell_y;
   assign rsp_chan.hit_along         = rsp.hit_along;
   assign rsp_chan.hit_distance      = rsp.hit_distance;
   assign rsp_chan.face              = rsp.face;
   assign rsp_chan.wall_floor_tex    = rsp.wall_floor_tex;
   assign rsp_chan.wall_ceil_tex     = rsp.wall_ceil_tex;
   assign rsp_chan.near_floor_height = rsp.near_floor_height;
   assign rsp_chan.near_ceil_height  = rsp.near_ceil_height;
   assign rsp_chan.near_floor_tex    = rsp.near_floor_tex;
   assign rsp_chan.near_ceil_tex     = rsp.near_ceil_tex;
   assign rsp_chan.last_hit          = rsp.last_hit;

endmodule
